// ===== hw/rtl/bpmm_pkg.sv =====
// Package with constants and types for the balanced partition search unit.
`default_nettype none
package bpmm_pkg;

    localparam int MAX_PEOPLE = 24;
    localparam int HALF_MAX   = MAX_PEOPLE / 2;
    localparam int TBL_AW     = HALF_MAX;
    localparam int TBL_DEPTH  = 1 << TBL_AW;
    localparam int SCORE_W    = 31;
    localparam int CNT_W      = 5;
    localparam int HALF_W     = 4;
    localparam int SUM_W      = 37;
    localparam int GAP_W      = 36;
    localparam int MASK_W     = 24;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SUM,
        ST_INIT,
        ST_BRD,
        ST_BWR,
        ST_SRCH,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/balanced_partition_meet_in_middle_unit.sv =====
// Top level of the balanced two-team partition search unit.
// Operation: loading takes one transfer per cycle; after the last person the search builds
// the front and back half tables in turn, then runs the pair sweep (one front/back table
// read pair per cycle) and its drain, then registers the result for the output.
// Input is stalled during the search; throughput is one person per cycle while loading.
// Reset clears the loaded count, the output valid flag, the best split and people_count (to 2).
`default_nettype none
module balanced_partition_meet_in_middle_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [bpmm_pkg::SCORE_W-1:0]   score_a,
    input  wire logic [bpmm_pkg::SCORE_W-1:0]   score_b,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [bpmm_pkg::MASK_W-1:0]         team_mask,
    output logic [bpmm_pkg::GAP_W-1:0]          min_gap,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bpmm_pkg::CNT_W-1:0]     people_count
);

    localparam int AW = bpmm_pkg::TBL_AW;
    localparam int SW = bpmm_pkg::SUM_W;
    localparam int HW = bpmm_pkg::HALF_W;
    localparam int CW = bpmm_pkg::CNT_W;

    function automatic logic [HW-1:0] low_bit(input logic [AW-1:0] v);
        logic [HW-1:0] r;
        r = '0;
        for (int b = AW - 1; b >= 0; b--) begin
            if (v[b]) r = HW'(b);
        end
        return r;
    endfunction

    function automatic logic [HW:0] ones(input logic [AW-1:0] v);
        logic [HW:0] c;
        c = '0;
        for (int b = 0; b < AW; b++) begin
            c = c + (HW+1)'(v[b]);
        end
        return c;
    endfunction

    bpmm_pkg::state_t state_reg, state_next;

    logic [CW-1:0]  pc_reg;
    logic [CW-1:0]  loaded_reg, loaded_next;
    logic [HW-1:0]  h_reg, h_next;
    logic           side_reg, side_next;
    logic [HW-1:0]  k_reg, k_next;
    logic [AW-1:0]  m_reg, m_next;
    logic [AW-1:0]  i_reg, i_next;
    logic [AW-1:0]  j_reg, j_next;
    logic           p1_vld_reg, p1_vld_next;
    logic           p1_last_reg, p1_last_next;
    logic           p2_vld_reg, p2_vld_next;
    logic           p2_last_reg, p2_last_next;
    logic [SW-1:0]  best_gap_reg, best_gap_next;
    logic [bpmm_pkg::MASK_W-1:0] best_mask_reg, best_mask_next;
    logic           out_valid_reg, out_valid_next;

    logic signed [SW-1:0] acc_reg, acc_next;
    logic [SW-1:0]  d_reg, d_next;
    logic [AW-1:0]  p1_i_reg, p1_j_reg;
    logic [bpmm_pkg::GAP_W-1:0]  p2_gap_reg;
    logic [bpmm_pkg::MASK_W-1:0] p2_mask_reg;
    logic [bpmm_pkg::MASK_W-1:0] team_mask_reg;
    logic [bpmm_pkg::GAP_W-1:0]  min_gap_reg;

    logic [bpmm_pkg::SCORE_W-1:0] gain_mem [bpmm_pkg::MAX_PEOPLE];
    logic [bpmm_pkg::SCORE_W-1:0] loss_mem [bpmm_pkg::MAX_PEOPLE];
    logic signed [SW-1:0] front_mem [bpmm_pkg::TBL_DEPTH];
    logic signed [SW-1:0] back_mem  [bpmm_pkg::TBL_DEPTH];
    logic signed [SW-1:0] front_rd_reg, back_rd_reg;

    logic [CW-1:0]  n_eff;
    logic [CW-1:0]  ld_idx;
    logic [CW-1:0]  ld_cnt;
    logic           in_take;
    logic           st_we;
    logic [CW-1:0]  rd_p;
    logic [CW-1:0]  base;
    logic [AW-1:0]  tm1;
    logic [AW-1:0]  bld_addr;
    logic [AW-1:0]  front_raddr, back_raddr;
    logic           front_we, back_we;
    logic [AW-1:0]  waddr;
    logic signed [SW-1:0] wdata;
    logic signed [SW-1:0] t_sum;
    logic [SW-1:0]  t_abs;
    logic           srch_issue;
    logic           srch_last;
    logic [bpmm_pkg::MASK_W-1:0] p1_mask;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != bpmm_pkg::ST_LOAD);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign team_mask = team_mask_reg;
    assign min_gap   = min_gap_reg;

    always_comb
    begin
        if (pc_reg < CW'(2)) begin
            n_eff = CW'(2);
        end else if (pc_reg > CW'(bpmm_pkg::MAX_PEOPLE)) begin
            n_eff = CW'(bpmm_pkg::MAX_PEOPLE);
        end else begin
            n_eff = pc_reg;
        end
        n_eff[0] = 1'b0;
    end

    assign ld_idx   = (loaded_reg >= CW'(bpmm_pkg::MAX_PEOPLE)) ? '0 : loaded_reg;
    assign ld_cnt   = ld_idx + CW'(1);
    assign base     = side_reg ? CW'(h_reg) : '0;
    assign tm1      = AW'((({1'b0, AW'(0)} | (AW+1)'(1)) << h_reg) - (AW+1)'(1));
    assign bld_addr = m_reg & (m_reg - AW'(1));

    always_comb
    begin
        if (state_reg == bpmm_pkg::ST_SUM) begin
            rd_p = base + CW'(k_reg);
        end else begin
            rd_p = base + CW'(h_reg) - CW'(1) - CW'(low_bit(m_reg));
        end
    end

    assign srch_issue  = (state_reg == bpmm_pkg::ST_SRCH);
    assign srch_last   = (i_reg == tm1) && (j_reg == tm1);
    assign front_raddr = srch_issue ? i_reg : bld_addr;
    assign back_raddr  = srch_issue ? j_reg : bld_addr;
    assign waddr       = (state_reg == bpmm_pkg::ST_INIT) ? '0 : m_reg;
    assign wdata       = (state_reg == bpmm_pkg::ST_INIT) ? acc_reg
                       : ((side_reg ? back_rd_reg : front_rd_reg) - $signed(d_reg));
    assign front_we    = !side_reg && ((state_reg == bpmm_pkg::ST_INIT)
                                    || (state_reg == bpmm_pkg::ST_BWR));
    assign back_we     = side_reg && ((state_reg == bpmm_pkg::ST_INIT)
                                   || (state_reg == bpmm_pkg::ST_BWR));

    assign t_sum   = front_rd_reg + back_rd_reg;
    assign t_abs   = t_sum[SW-1] ? SW'(-t_sum) : SW'(t_sum);
    assign p1_mask = (bpmm_pkg::MASK_W'(p1_i_reg) << h_reg) | bpmm_pkg::MASK_W'(p1_j_reg);

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        h_next         = h_reg;
        side_next      = side_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        acc_next       = acc_reg;
        d_next         = d_reg;
        best_gap_next  = best_gap_reg;
        best_mask_next = best_mask_reg;
        out_valid_next = out_valid_reg;
        st_we          = 1'b0;
        p1_vld_next    = srch_issue && ((ones(i_reg) + ones(j_reg)) == (HW+1)'(h_reg));
        p1_last_next   = srch_issue && srch_last;
        p2_vld_next    = p1_vld_reg;
        p2_last_next   = p1_last_reg;

        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end

        if (p2_vld_reg && ({1'b0, p2_gap_reg} < best_gap_reg)) begin
            best_gap_next  = {1'b0, p2_gap_reg};
            best_mask_next = p2_mask_reg;
        end

        unique case (state_reg)
            bpmm_pkg::ST_LOAD:
            begin
                if (in_take) begin
                    st_we = 1'b1;
                    if (ld_cnt >= n_eff) begin
                        loaded_next    = '0;
                        h_next         = HW'(n_eff >> 1);
                        side_next      = 1'b0;
                        k_next         = '0;
                        acc_next       = '0;
                        best_gap_next  = '1;
                        best_mask_next = '0;
                        state_next     = bpmm_pkg::ST_SUM;
                    end else begin
                        loaded_next = ld_cnt;
                    end
                end
            end
            bpmm_pkg::ST_SUM:
            begin
                acc_next = acc_reg + $signed(SW'(gain_mem[rd_p]));
                k_next   = k_reg + HW'(1);
                if (k_reg == h_reg - HW'(1)) begin
                    state_next = bpmm_pkg::ST_INIT;
                end
            end
            bpmm_pkg::ST_INIT:
            begin
                m_next     = AW'(1);
                state_next = bpmm_pkg::ST_BRD;
            end
            bpmm_pkg::ST_BRD:
            begin
                d_next     = SW'(gain_mem[rd_p]) + SW'(loss_mem[rd_p]);
                state_next = bpmm_pkg::ST_BWR;
            end
            bpmm_pkg::ST_BWR:
            begin
                if (m_reg == tm1) begin
                    if (!side_reg) begin
                        side_next  = 1'b1;
                        k_next     = '0;
                        acc_next   = '0;
                        state_next = bpmm_pkg::ST_SUM;
                    end else begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = bpmm_pkg::ST_SRCH;
                    end
                end else begin
                    m_next     = m_reg + AW'(1);
                    state_next = bpmm_pkg::ST_BRD;
                end
            end
            bpmm_pkg::ST_SRCH:
            begin
                if (j_reg == tm1) begin
                    j_next = '0;
                    i_next = i_reg + AW'(1);
                end else begin
                    j_next = j_reg + AW'(1);
                end
                if (srch_last) begin
                    state_next = bpmm_pkg::ST_DRAIN;
                end
            end
            bpmm_pkg::ST_DRAIN:
            begin
                if (p2_last_reg) begin
                    state_next = bpmm_pkg::ST_DONE;
                end
            end
            bpmm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall) begin
                    out_valid_next = 1'b1;
                    state_next     = bpmm_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = bpmm_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= bpmm_pkg::ST_LOAD;
            pc_reg        <= CW'(2);
            loaded_reg    <= '0;
            h_reg         <= HW'(1);
            side_reg      <= 1'b0;
            k_reg         <= '0;
            m_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            p1_vld_reg    <= 1'b0;
            p1_last_reg   <= 1'b0;
            p2_vld_reg    <= 1'b0;
            p2_last_reg   <= 1'b0;
            best_gap_reg  <= '1;
            best_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready) begin
                pc_reg <= people_count;
            end
            loaded_reg    <= loaded_next;
            h_reg         <= h_next;
            side_reg      <= side_next;
            k_reg         <= k_next;
            m_reg         <= m_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            p1_vld_reg    <= p1_vld_next;
            p1_last_reg   <= p1_last_next;
            p2_vld_reg    <= p2_vld_next;
            p2_last_reg   <= p2_last_next;
            best_gap_reg  <= best_gap_next;
            best_mask_reg <= best_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        d_reg       <= d_next;
        p1_i_reg    <= i_reg;
        p1_j_reg    <= j_reg;
        p2_gap_reg  <= bpmm_pkg::GAP_W'(t_abs);
        p2_mask_reg <= p1_mask;
        if (st_we) begin
            gain_mem[ld_idx] <= score_a;
            loss_mem[ld_idx] <= score_b;
        end
        if ((state_reg == bpmm_pkg::ST_DONE) && (!out_valid_reg || !out_stall)) begin
            team_mask_reg <= best_mask_reg;
            min_gap_reg   <= bpmm_pkg::GAP_W'(best_gap_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_we) begin
            front_mem[waddr] <= wdata;
        end
        front_rd_reg <= front_mem[front_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (back_we) begin
            back_mem[waddr] <= wdata;
        end
        back_rd_reg <= back_mem[back_raddr];
    end

    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bpmm_pkg::ST_DONE))
        else $error("result raised outside the done state");

    a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($countones(team_mask_reg) == int'(h_reg)))
        else $error("result mask is not balanced");

    a_best_falls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpmm_pkg::ST_DRAIN) |-> (best_gap_reg <= $past(best_gap_reg)))
        else $error("best gap grew during the sweep");

endmodule
`default_nettype wire

// ===== verif/balanced_partition_meet_in_middle_unit_tb.sv =====
// Testbench for the balanced partition search unit: scored loads, predicted best split, checks.
`default_nettype none
module balanced_partition_meet_in_middle_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PEOPLE = bpmm_pkg::MAX_PEOPLE;
    localparam int SCORE_W    = bpmm_pkg::SCORE_W;
    localparam int CNT_W      = bpmm_pkg::CNT_W;
    localparam int GAP_W      = bpmm_pkg::GAP_W;
    localparam int MASK_W     = bpmm_pkg::MASK_W;

    localparam longint CYCLE_LIMIT = 12000000;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    typedef struct {
        logic [MASK_W-1:0] mask;
        logic [GAP_W-1:0]  gap;
    } split_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [SCORE_W-1:0]  score_a;
    logic [SCORE_W-1:0]  score_b;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [MASK_W-1:0]   team_mask;
    logic [GAP_W-1:0]    min_gap;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CNT_W-1:0]    people_count;

    balanced_partition_meet_in_middle_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .score_a      (score_a),
        .score_b      (score_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .team_mask    (team_mask),
        .min_gap      (min_gap),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .people_count (people_count)
    );

    split_t            pending_splits[$];
    logic [CNT_W-1:0]  group_size_reg;
    logic [SCORE_W-1:0] gain_mem[MAX_PEOPLE];
    logic [SCORE_W-1:0] loss_mem[MAX_PEOPLE];
    int                people_loaded;
    int                last_half;
    bit                idle_enable;
    int                mismatches;
    int                splits_seen;
    int                people_sent;
    longint            cycle_count;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint half_sum(int h, int base, int m);
        longint s;
        s = 0;
        for (int i = 0; i < h; i++)
        begin
            if (m[h-1-i])
                s -= longint'(loss_mem[base+i]);
            else
                s += longint'(gain_mem[base+i]);
        end
        return s;
    endfunction

    // sorted, deduplicated half table with per-count group bounds
    function automatic void build_table(int h, int base, bit desc, ref longint sums[$],
                                        ref int masks[$], ref int lo[13], ref int hi[13]);
        longint unsigned keys[$];
        longint unsigned biased;
        longint s;
        int m;
        int c;
        int total;
        total = 1 << h;
        sums.delete();
        masks.delete();
        for (int k = 0; k <= 12; k++)
        begin
            lo[k] = 0;
            hi[k] = 0;
        end
        for (m = 0; m < total; m++)
        begin
            biased = longint'(half_sum(h, base, m)) + (64'd1 << 36);
            if (desc)
                biased = ((64'd1 << 37) - 1) - biased;
            keys.push_back((longint'($countones(m)) << 49) | (biased << 12) | m);
        end
        keys.sort();
        foreach (keys[x])
        begin
            m = int'(keys[x] & 12'hfff);
            c = $countones(m);
            s = half_sum(h, base, m);
            if (masks.size() > 0 && $countones(masks[$]) == c && sums[$] == s)
                continue;
            if (masks.size() == 0 || $countones(masks[$]) != c)
                lo[c] = masks.size();
            sums.push_back(s);
            masks.push_back(m);
            hi[c] = masks.size();
        end
    endfunction

    function automatic split_t best_split(int h);
        longint fs[$];
        longint bs[$];
        int fm[$];
        int bm[$];
        int flo[13];
        int fhi[13];
        int blo[13];
        int bhi[13];
        longint t;
        longint g;
        longint cm;
        longint best_g;
        longint best_m;
        int i;
        int j;
        split_t r;
        build_table(h, 0, 1'b0, fs, fm, flo, fhi);
        build_table(h, h, 1'b1, bs, bm, blo, bhi);
        best_g = (64'd1 << 37) - 1;
        best_m = 0;
        for (int k = 0; k <= h; k++)
        begin
            i = flo[k];
            j = blo[h-k];
            while (i < fhi[k] && j < bhi[h-k])
            begin
                t = fs[i] + bs[j];
                g = (t < 0) ? -t : t;
                cm = (longint'(fm[i]) << h) | longint'(bm[j]);
                if (g < best_g)
                begin
                    best_g = g;
                    best_m = cm;
                end
                else if (g == best_g && cm < best_m)
                    best_m = cm;
                if (t < 0)
                    i++;
                else
                    j++;
            end
        end
        r.mask = best_m[MASK_W-1:0];
        r.gap  = best_g[GAP_W-1:0];
        return r;
    endfunction

    function automatic int group_size();
        int n;
        n = group_size_reg;
        if (n < 2)
            n = 2;
        if (n > MAX_PEOPLE)
            n = MAX_PEOPLE;
        return n & ~1;
    endfunction

    function automatic void load_person(logic [SCORE_W-1:0] a, logic [SCORE_W-1:0] b);
        int n;
        n = group_size();
        if (people_loaded >= MAX_PEOPLE)
            people_loaded = 0;
        gain_mem[people_loaded] = a;
        loss_mem[people_loaded] = b;
        people_loaded++;
        if (people_loaded >= n)
        begin
            people_loaded = 0;
            last_half = n / 2;
            pending_splits.push_back(best_split(n / 2));
        end
    endfunction

    function automatic bit idle_now();
        return idle_enable && ($urandom_range(0, 99) < 14);
    endfunction

    task automatic send_person(logic [SCORE_W-1:0] a, logic [SCORE_W-1:0] b);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        score_a  <= a;
        score_b  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        load_person(a, b);
        people_sent++;
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        int busy;
        in_valid <= 1'b0;
        while (pending_splits.size() > 0)
            @(posedge clk);
        busy = 2 * (last_half + 2 + 2 * (1 << last_half)) + (1 << (2 * last_half)) + 20;
        repeat (busy) @(posedge clk);
    endtask

    task automatic write_group_size(logic [CNT_W-1:0] v);
        wait_drained();
        cfg_valid    <= 1'b1;
        people_count <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        group_size_reg = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [SCORE_W-1:0] rand_score(bit narrow);
        if (narrow)
            return SCORE_W'($urandom_range(0, 7));
        return SCORE_W'($urandom());
    endfunction

    task automatic send_group(int n, bit narrow);
        for (int p = 0; p < n; p++)
            send_person(rand_score(narrow), rand_score(narrow));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_splits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: mask %h gap %0d", team_mask, min_gap);
            end
            else
            begin
                if (team_mask !== pending_splits[0].mask || min_gap !== pending_splits[0].gap)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("split %0d: expected mask %h gap %0d, got mask %h gap %0d",
                                 splits_seen, pending_splits[0].mask, pending_splits[0].gap,
                                 team_mask, min_gap);
                end
                void'(pending_splits.pop_front());
                splits_seen++;
            end
        end
        out_stall <= idle_now();
    end

    task automatic test_score_extremes();
        write_group_size(CNT_W'(2));
        send_person('0, '0);
        send_person(SCORE_MAX, SCORE_MAX);
        send_person(SCORE_MAX, '0);
        send_person('0, SCORE_MAX);
        write_group_size(CNT_W'(4));
        send_person(SCORE_W'(31'h5555_5555), SCORE_W'(31'h2aaa_aaaa));
        send_person(SCORE_W'(31'h2aaa_aaaa), SCORE_W'(31'h5555_5555));
        send_person(SCORE_MAX, SCORE_MAX);
        send_person(SCORE_W'(1), SCORE_W'(1));
        for (int p = 0; p < 4; p++)
            send_person(SCORE_W'(3), SCORE_W'(3));
        release_input();
    endtask

    task automatic test_count_clamping();
        write_group_size(CNT_W'(0));
        send_person(SCORE_W'(5), SCORE_W'(9));
        send_person(SCORE_W'(9), SCORE_W'(5));
        write_group_size(CNT_W'(1));
        send_person(SCORE_W'(2), SCORE_W'(2));
        send_person(SCORE_W'(2), SCORE_W'(2));
        write_group_size(CNT_W'(5));
        send_group(4, 1'b1);
        release_input();
    endtask

    task automatic test_count_lowered_mid_load();
        write_group_size('1);
        send_group(5, 1'b0);
        release_input();
        write_group_size(CNT_W'(4));
        send_person(SCORE_W'(7), SCORE_W'(1));
        release_input();
    endtask

    task automatic test_random_groups(int goal);
        int n;
        int r;
        int big_left;
        big_left = 3;
        while (people_sent < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                n = 2 * $urandom_range(1, 3);
            else if (r < 96 || big_left == 0)
                n = 2 * $urandom_range(4, 5);
            else
            begin
                n = 2 * $urandom_range(6, 8);
                big_left--;
            end
            write_group_size(CNT_W'(n + $urandom_range(0, 1)));
            repeat ($urandom_range(1, 6))
                send_group(n, $urandom_range(0, 2) == 0);
            if ($urandom_range(0, 4) == 0)
                send_group($urandom_range(1, n - 1), 1'b0);
            release_input();
        end
    endtask

    task automatic test_no_idle_stretch();
        idle_enable = 1'b0;
        write_group_size(CNT_W'(4));
        repeat (20)
            send_group(4, 1'b0);
        release_input();
        idle_enable = 1'b1;
    endtask

    task automatic test_sender_pause();
        write_group_size(CNT_W'(6));
        repeat (4)
        begin
            send_group(6, 1'b1);
            release_input();
            while (pending_splits.size() > 0)
                @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        score_a      <= '0;
        score_b      <= '0;
        cfg_valid    <= 1'b0;
        people_count <= '0;
        group_size_reg = CNT_W'(2);
        people_loaded  = 0;
        last_half      = 1;
        idle_enable    = 1'b1;
        mismatches     = 0;
        splits_seen    = 0;
        people_sent    = 0;
        cycle_count    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_score_extremes();
        test_count_clamping();
        test_count_lowered_mid_load();
        test_no_idle_stretch();
        test_sender_pause();
        test_random_groups(1700);
        wait_drained();

        $display("covered %0d people loaded and %0d splits checked, group sizes 2 to 16,",
                 people_sent, splits_seen);
        $display("clamped and lowered counts, wide and narrow scores, random stalls");
        if (mismatches == 0 && pending_splits.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
